[sv/first_fit_segment_allocator_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit segment allocator
// Each macro expands to a concurrent assertion clocked by clk and disabled
// while rst_n is low; synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define FFSA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ffsa assertion failed");
// Check that a condition holds in the cycle after a trigger
`define FFSA_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("ffsa assertion failed");
`else
`define FFSA_ASSERT(lbl, prop)
`define FFSA_ASSERT_NEXT(lbl, trig, cons)
`endif

`endif

[sv/ffsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, codes and controller/datapath interface of the allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    // Operation codes
    localparam logic [1:0] FUNC_INIT   = 2'd0;
    localparam logic [1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [1:0] FUNC_FREE   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOTALLOC = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W      = 1;
    localparam logic [0:0]  CFG_HEAP_START = 1'b0;
    localparam logic [0:0]  CFG_HEAP_END   = 1'b1;
    localparam logic [31:0] HEAP_START_RST = 32'd0;
    localparam logic [31:0] HEAP_END_RST   = 32'd1048576;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] req_size;
        logic [31:0] address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
    } out_item_t;

    // One segment table entry
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] bytes;
        logic        in_use;
    } entry_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_SET_RES,
        OP_ROUND,
        OP_NEED,
        OP_RD_IDX,
        OP_NEXT,
        OP_HIT,
        OP_WR_USE,
        OP_SHUP_INIT,
        OP_RD_UP,
        OP_WR_UP,
        OP_WR_SPLIT,
        OP_WR_ALLOC,
        OP_RD_NXT,
        OP_MERGE_NEXT,
        OP_MERGE_PREV,
        OP_RD_DN,
        OP_WR_DN,
        OP_SHDN_END,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] st;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       req_zero;
        logic       range_bad;
        logic       round_done;
        logic       scan_end;
        logic       hit;
        logic       split;
        logic       full;
        logic       shup_end;
        logic       shdn_end;
        logic       out_busy;
    } dp_status_t;

endpackage

[sv/ffsa_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_round
// Round-down unit: clears the low bits of a 33-bit value so that it becomes a
// multiple of BLOCK_BYTES (a power of two); the result is registered and is
// ready in the cycle after start.
// ----------------------------------------------------------------------------
module ffsa_round
#(
    parameter int unsigned BLOCK_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] dividend,
    output logic        done,
    output logic [32:0] rounded
);

    localparam int unsigned LB = $clog2(BLOCK_BYTES);

    logic        done_reg;
    logic [32:0] val_reg;

    // Flag completion in the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // Capture the value with the sub-block bits dropped
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= {dividend[32:LB], {LB{1'b0}}};
        end
    end

    assign done    = done_reg;
    assign rounded = val_reg;

endmodule

[sv/ffsa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_datapath
// Segment table memory, scan and merge arithmetic, configuration registers
// and the output register.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_core_defines.svh"

module ffsa_datapath
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned BLOCK_BYTES  = 64,
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  in_item_t             in_data,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 out_stall,
    output logic                 out_valid,
    output out_item_t            out_data
);

    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [32:0]   HDR     = 33'(HEADER_BYTES);
    localparam logic [32:0]   BLK_M1  = 33'(BLOCK_BYTES - 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    entry_t mem [MAX_SEGMENTS];

    logic [31:0]   heap_start_reg;
    logic [31:0]   heap_end_reg;
    logic [CW-1:0] count_reg;
    logic          out_valid_reg;
    in_item_t      item_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] src_reg;
    logic [CW-1:0] dst_reg;
    logic [32:0]   need_reg;
    entry_t        cur_reg;
    entry_t        prev_reg;
    logic          prev_vld_reg;
    logic          mn_reg;
    entry_t        rd_reg;
    out_item_t     res_reg;
    out_item_t     out_reg;

    logic          round_done;
    logic [32:0]   round_need;
    logic          init_fits;
    logic          alloc_fit;
    logic          free_match;
    logic          nxt_vld;
    logic          mn;
    logic          mp;
    logic [31:0]   cur_bytes_m;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    entry_t        mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;
    logic [CW-1:0] idx_p1;

    ffsa_round #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_ROUND),
        .dividend ({1'b0, item_reg.req_size} + BLK_M1),
        .done     (round_done),
        .rounded  (round_need)
    );

    // Scan, split and merge conditions
    always_comb
    begin
        idx_p1      = idx_reg + 1'b1;
        init_fits   = {1'b0, heap_end_reg} >= ({1'b0, heap_start_reg} + HDR);
        alloc_fit   = !rd_reg.in_use && ({1'b0, rd_reg.bytes} >= need_reg);
        free_match  = rd_reg.in_use
                      && (({1'b0, rd_reg.offset} + HDR) == {1'b0, item_reg.address});
        nxt_vld     = idx_p1 < count_reg;
        mn          = nxt_vld && !rd_reg.in_use
                      && (({1'b0, cur_reg.offset} + HDR + {1'b0, cur_reg.bytes})
                          == {1'b0, rd_reg.offset});
        cur_bytes_m = cur_reg.bytes + HEADER_BYTES[31:0] + rd_reg.bytes;
        mp          = prev_vld_reg && !prev_reg.in_use
                      && (({1'b0, prev_reg.offset} + HDR + {1'b0, prev_reg.bytes})
                          == {1'b0, cur_reg.offset});
    end

    // Status to the controller
    always_comb
    begin
        status.func       = item_reg.func;
        status.req_zero   = (item_reg.req_size == 32'd0);
        status.range_bad  = (item_reg.address == 32'd0)
                            || (item_reg.address < heap_start_reg)
                            || (item_reg.address >= heap_end_reg);
        status.round_done = round_done;
        status.scan_end   = (idx_reg == count_reg);
        status.hit        = (item_reg.func == FUNC_ALLOC) ? alloc_fit : free_match;
        status.split      = (({1'b0, cur_reg.bytes} - need_reg) >= HDR);
        status.full       = (count_reg >= MAX_CNT);
        status.shup_end   = (src_reg == idx_p1);
        status.shdn_end   = (src_reg == count_reg);
        status.out_busy   = out_valid_reg && out_stall;
    end

    // Table memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg[IW-1:0];
        mem_wd = cur_reg;
        mem_re = 1'b0;
        mem_ra = idx_reg[IW-1:0];
        unique case (cmd.op)
            OP_INIT:
            begin
                mem_we = init_fits;
                mem_wa = '0;
                mem_wd = '{offset: heap_start_reg,
                           bytes: heap_end_reg - heap_start_reg - HEADER_BYTES[31:0],
                           in_use: 1'b0};
            end
            OP_WR_USE:
            begin
                mem_we        = 1'b1;
                mem_wd.in_use = 1'b1;
            end
            OP_WR_UP:
            begin
                mem_we = 1'b1;
                mem_wa = src_reg[IW-1:0];
                mem_wd = rd_reg;
            end
            OP_WR_SPLIT:
            begin
                mem_we = 1'b1;
                mem_wa = idx_p1[IW-1:0];
                mem_wd = '{offset: cur_reg.offset + HEADER_BYTES[31:0] + need_reg[31:0],
                           bytes: cur_reg.bytes - need_reg[31:0] - HEADER_BYTES[31:0],
                           in_use: 1'b0};
            end
            OP_WR_ALLOC:
            begin
                mem_we = 1'b1;
                mem_wd = '{offset: cur_reg.offset, bytes: need_reg[31:0], in_use: 1'b1};
            end
            OP_MERGE_PREV:
            begin
                mem_we = 1'b1;
                if (mp)
                begin
                    mem_wa = idx_reg[IW-1:0] - 1'b1;
                    mem_wd = '{offset: prev_reg.offset,
                               bytes: prev_reg.bytes + HEADER_BYTES[31:0] + cur_reg.bytes,
                               in_use: 1'b0};
                end
            end
            OP_WR_DN:
            begin
                mem_we = 1'b1;
                mem_wa = dst_reg[IW-1:0];
                mem_wd = rd_reg;
            end
            OP_RD_IDX:
            begin
                mem_re = 1'b1;
            end
            OP_RD_UP:
            begin
                mem_re = 1'b1;
                mem_ra = src_reg[IW-1:0] - 1'b1;
            end
            OP_RD_NXT:
            begin
                mem_re = 1'b1;
                mem_ra = idx_p1[IW-1:0];
            end
            OP_RD_DN:
            begin
                mem_re = 1'b1;
                mem_ra = src_reg[IW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Segment table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    // Hold configuration, table fill count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= HEAP_START_RST;
            heap_end_reg   <= HEAP_END_RST;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HEAP_START: heap_start_reg <= cfg_data;
                    CFG_HEAP_END:   heap_end_reg   <= cfg_data;
                    default:        heap_end_reg   <= heap_end_reg;
                endcase
            end
            unique case (cmd.op)
                OP_INIT:     count_reg <= init_fits ? CW'(1) : '0;
                OP_WR_ALLOC: count_reg <= count_reg + 1'b1;
                OP_SHDN_END: count_reg <= dst_reg;
                default:     count_reg <= count_reg;
            endcase
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                item_reg     <= in_data;
                idx_reg      <= '0;
                prev_vld_reg <= 1'b0;
                res_reg      <= '{result_address: 32'd0, status: ST_OK};
            end
            OP_SET_RES:
            begin
                res_reg <= '{result_address: 32'd0, status: cmd.st};
            end
            OP_NEED:
            begin
                need_reg <= round_need;
            end
            OP_NEXT:
            begin
                prev_reg     <= rd_reg;
                prev_vld_reg <= 1'b1;
                idx_reg      <= idx_p1;
            end
            OP_HIT:
            begin
                cur_reg <= rd_reg;
            end
            OP_WR_USE, OP_WR_ALLOC:
            begin
                res_reg.result_address <= cur_reg.offset + HEADER_BYTES[31:0];
            end
            OP_SHUP_INIT:
            begin
                src_reg <= count_reg;
            end
            OP_WR_UP:
            begin
                src_reg <= src_reg - 1'b1;
            end
            OP_MERGE_NEXT:
            begin
                mn_reg         <= mn;
                cur_reg.in_use <= 1'b0;
                if (mn)
                begin
                    cur_reg.bytes <= cur_bytes_m;
                end
            end
            OP_MERGE_PREV:
            begin
                src_reg <= idx_p1 + CW'(mn_reg);
                dst_reg <= mp ? idx_reg : idx_p1;
            end
            OP_WR_DN:
            begin
                src_reg <= src_reg + 1'b1;
                dst_reg <= dst_reg + 1'b1;
            end
            OP_OUT:
            begin
                out_reg <= res_reg;
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `FFSA_ASSERT(a_count_max, count_reg <= MAX_CNT)
    `FFSA_ASSERT(a_write_in_table, mem_we |-> (CW'(mem_wa) <= count_reg))
    `FFSA_ASSERT(a_hit_in_table, (cmd.op == OP_HIT) |-> (idx_reg < count_reg))
    `FFSA_ASSERT_NEXT(a_out_loaded, cmd.op == OP_OUT, out_valid_reg)

endmodule

[sv/ffsa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer for init, allocate and free: scan, shift and merge steps.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ROUND_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC_HIT,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SPLIT_HI,
        S_FREE_NRD,
        S_FREE_MN,
        S_FREE_MP,
        S_SHDN_RD,
        S_SHDN_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Choose the datapath operation and next state
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        cmd.st     = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.func)
                    FUNC_INIT:
                    begin
                        cmd.op     = OP_INIT;
                        state_next = S_FINISH;
                    end
                    FUNC_ALLOC:
                    begin
                        if (status.req_zero)
                        begin
                            cmd.op     = OP_SET_RES;
                            cmd.st     = ST_ZERO;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.op     = OP_ROUND;
                            state_next = S_ROUND_WAIT;
                        end
                    end
                    FUNC_FREE:
                    begin
                        if (status.range_bad)
                        begin
                            cmd.op     = OP_SET_RES;
                            cmd.st     = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ROUND_WAIT:
            begin
                if (status.round_done)
                begin
                    cmd.op     = OP_NEED;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (status.scan_end)
                begin
                    cmd.op     = OP_SET_RES;
                    cmd.st     = (status.func == FUNC_ALLOC) ? ST_NOFIT : ST_NOTALLOC;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (status.hit)
                begin
                    cmd.op     = OP_HIT;
                    state_next = (status.func == FUNC_ALLOC) ? S_ALLOC_HIT : S_FREE_NRD;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_ALLOC_HIT:
            begin
                priority if (!status.split)
                begin
                    cmd.op     = OP_WR_USE;
                    state_next = S_FINISH;
                end
                else if (status.full)
                begin
                    cmd.op     = OP_SET_RES;
                    cmd.st     = ST_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_SHUP_INIT;
                    state_next = S_SHUP_RD;
                end
            end
            S_SHUP_RD:
            begin
                if (status.shup_end)
                begin
                    cmd.op     = OP_WR_SPLIT;
                    state_next = S_SPLIT_HI;
                end
                else
                begin
                    cmd.op     = OP_RD_UP;
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                cmd.op     = OP_WR_UP;
                state_next = S_SHUP_RD;
            end
            S_SPLIT_HI:
            begin
                cmd.op     = OP_WR_ALLOC;
                state_next = S_FINISH;
            end
            S_FREE_NRD:
            begin
                cmd.op     = OP_RD_NXT;
                state_next = S_FREE_MN;
            end
            S_FREE_MN:
            begin
                cmd.op     = OP_MERGE_NEXT;
                state_next = S_FREE_MP;
            end
            S_FREE_MP:
            begin
                cmd.op     = OP_MERGE_PREV;
                state_next = S_SHDN_RD;
            end
            S_SHDN_RD:
            begin
                if (status.shdn_end)
                begin
                    cmd.op     = OP_SHDN_END;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_RD_DN;
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                cmd.op     = OP_WR_DN;
                state_next = S_SHDN_RD;
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[sv/first_fit_segment_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit heap allocator with splitting and coalescing of free segments.
// ----------------------------------------------------------------------------
// One transaction is worked at a time and answers with one result; BLOCK_BYTES
// must be a power of two. Timing is set by the single-port segment table
// memory, which is read and written one entry per cycle. Init, a zero-size
// allocate, a free out of range and the unused operation go straight from
// dispatch to the result; allocate scans the segments in order and, when a
// split opens a slot, moves the entries behind the hit up; free scans the
// segments, merges with free neighbours and then walks the whole tail behind
// the freed entry to close the slots left by merges; a miss scans every
// segment in the table. The final step waits while the output register still
// holds an unaccepted result. A new transaction is taken while the previous
// result still waits in the output register.

module first_fit_segment_allocator_core
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned BLOCK_BYTES  = 64,
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller
    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    ffsa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Configuration writes land at once
    assign cfg_ready = 1'b1;

endmodule

[sim/ffsa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_checker
// Watches the request, result and register channels of the allocator, keeps
// its own copy of the segment table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module ffsa_checker
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned BLOCK_BYTES  = 64,
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fail_count,
    output int                   pending_count,
    output int                   ok_alloc_count,
    output logic [31:0]          last_alloc_addr
);

    logic [31:0] heap_lo;
    logic [31:0] heap_hi;
    entry_t      seg_tab[MAX_SEGMENTS];
    int          seg_num;
    out_item_t   expected_results[$];

    assign pending_count = expected_results.size();

    // Remove entry pos, shifting the tail down
    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < seg_num; i++)
            seg_tab[i] = seg_tab[i + 1];
        seg_num--;
    endfunction

    // Coalesce entry pos with its successor when both are free and touching
    function automatic void coalesce(int pos);
        logic [32:0] tail;
        if (pos + 1 >= seg_num) return;
        if (seg_tab[pos].in_use || seg_tab[pos + 1].in_use) return;
        tail = {1'b0, seg_tab[pos].offset} + HEADER_BYTES + seg_tab[pos].bytes;
        if (tail != {1'b0, seg_tab[pos + 1].offset}) return;
        seg_tab[pos].bytes = seg_tab[pos].bytes + HEADER_BYTES + seg_tab[pos + 1].bytes;
        drop_entry(pos + 1);
    endfunction

    function automatic out_item_t predict_result(in_item_t req);
        out_item_t   res;
        logic [33:0] need;
        logic [33:0] spare;
        res = '0;
        res.status = ST_OK;
        case (req.func)
            FUNC_INIT:
            begin
                seg_num = 0;
                if ({1'b0, heap_hi} >= {1'b0, heap_lo} + HEADER_BYTES)
                begin
                    seg_tab[0].offset = heap_lo;
                    seg_tab[0].bytes  = heap_hi - heap_lo - HEADER_BYTES;
                    seg_tab[0].in_use = 1'b0;
                    seg_num = 1;
                end
            end
            FUNC_ALLOC:
            begin
                if (req.req_size == 0)
                    res.status = ST_ZERO;
                else
                begin
                    need = ({2'b0, req.req_size} + BLOCK_BYTES - 1) / BLOCK_BYTES * BLOCK_BYTES;
                    res.status = ST_NOFIT;
                    for (int i = 0; i < seg_num; i++)
                    begin
                        if (seg_tab[i].in_use || {2'b0, seg_tab[i].bytes} < need) continue;
                        spare = {2'b0, seg_tab[i].bytes} - need;
                        if (spare >= HEADER_BYTES)
                        begin
                            if (seg_num >= MAX_SEGMENTS)
                            begin
                                res.status = ST_FULL;
                                break;
                            end
                            for (int j = seg_num; j > i + 1; j--)
                                seg_tab[j] = seg_tab[j - 1];
                            seg_num++;
                            seg_tab[i + 1].offset = seg_tab[i].offset + HEADER_BYTES + need[31:0];
                            seg_tab[i + 1].bytes  = spare[31:0] - HEADER_BYTES;
                            seg_tab[i + 1].in_use = 1'b0;
                            seg_tab[i].bytes = need[31:0];
                        end
                        seg_tab[i].in_use = 1'b1;
                        res.result_address = seg_tab[i].offset + HEADER_BYTES;
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            FUNC_FREE:
            begin
                if (req.address == 0 || req.address < heap_lo || req.address >= heap_hi)
                    res.status = ST_RANGE;
                else
                begin
                    res.status = ST_NOTALLOC;
                    for (int i = 0; i < seg_num; i++)
                    begin
                        if (!seg_tab[i].in_use) continue;
                        if ({1'b0, seg_tab[i].offset} + HEADER_BYTES != {1'b0, req.address})
                            continue;
                        seg_tab[i].in_use = 1'b0;
                        coalesce(i);
                        if (i > 0) coalesce(i - 1);
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Track registers, predict on each request, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_res;
        if (!rst_n)
        begin
            heap_lo = HEAP_START_RST;
            heap_hi = HEAP_END_RST;
            seg_num = 0;
            fail_count = 0;
            ok_alloc_count = 0;
            last_alloc_addr = 32'd0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HEAP_START) heap_lo = cfg_data;
                else heap_hi = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.result_address != out_data.result_address)
                    begin
                        $display("%0t: result_address expected %h actual %h", $time,
                                 exp_res.result_address, out_data.result_address);
                        fail_count++;
                    end
                    if (exp_res.status != out_data.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_res.status, out_data.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                exp_res = predict_result(in_data);
                if (in_data.func == FUNC_ALLOC && exp_res.status == ST_OK)
                begin
                    ok_alloc_count++;
                    last_alloc_addr = exp_res.result_address;
                end
                expected_results.push_back(exp_res);
            end
        end
    end

endmodule

[sim/tb_first_fit_segment_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_segment_allocator_core
// Drives init, allocate and free sequences with random gaps and output
// stalls over several heap windows; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_first_fit_segment_allocator_core;
    import ffsa_pkg::*;

    localparam int unsigned MAX_SEG   = 64;
    localparam int unsigned BLOCK_SZ  = 64;
    localparam int unsigned HEADER_SZ = 16;
    localparam int          CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   fail_count;
    int                   pending_count;
    int                   ok_alloc_count;
    logic [31:0]          last_alloc_addr;
    int                   cycle_count;
    logic [31:0]          live_addrs[$];
    logic [31:0]          cur_lo;
    logic [31:0]          cur_hi;

    first_fit_segment_allocator_core #(
        .MAX_SEGMENTS(MAX_SEG), .BLOCK_BYTES(BLOCK_SZ), .HEADER_BYTES(HEADER_SZ)
    ) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ffsa_checker #(
        .MAX_SEGMENTS(MAX_SEG), .BLOCK_BYTES(BLOCK_SZ), .HEADER_BYTES(HEADER_SZ)
    ) i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .ok_alloc_count(ok_alloc_count), .last_alloc_addr(last_alloc_addr)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall the result side at random, with stall-free stretches
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(0, 99) < 30 ? 0 : gap_len();
            out_stall <= (n != 0);
            repeat (n > 0 ? n : $urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Send one request transaction, with an optional gap first
    task automatic send_req(input logic [1:0] fn, input logic [31:0] sz,
                            input logic [31:0] ad);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.func <= fn;
        in_data.req_size <= sz;
        in_data.address <= ad;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Let the block drain before touching registers
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_heap(input logic [31:0] lo, input logic [31:0] hi);
        wait_quiet();
        write_reg(CFG_HEAP_START, lo);
        write_reg(CFG_HEAP_END, hi);
        cur_lo = lo;
        cur_hi = hi;
        live_addrs.delete();
    endtask

    // Random size: mostly small, sometimes huge
    function automatic logic [31:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 0;
        if (r < 8) return $urandom();
        if (r < 80) return $urandom_range(1, 300);
        return $urandom_range(1, 20000);
    endfunction

    // Random traffic on the current window, tracking our own allocations
    task automatic run_traffic(input int count);
        int          r;
        int          k;
        logic [31:0] ad;
        int          before_ok;
        send_req(FUNC_INIT, $urandom(), $urandom());
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                before_ok = ok_alloc_count;
                send_req(FUNC_ALLOC, rand_size(), $urandom());
                in_valid <= 1'b0;
                @(posedge clk);
                if (ok_alloc_count != before_ok)
                    live_addrs.push_back(last_alloc_addr);
            end
            else if (r < 85 && live_addrs.size() > 0)
            begin
                k = $urandom_range(0, live_addrs.size() - 1);
                ad = live_addrs[k];
                live_addrs.delete(k);
                send_req(FUNC_FREE, $urandom(), ad);
            end
            else if (r < 97)
            begin
                ad = $urandom_range(0, 3) == 0 ? $urandom() : cur_lo + ($urandom() % 4096);
                send_req(FUNC_FREE, $urandom(), ad);
            end
            else if (r < 99)
            begin
                send_req(FUNC_INIT, $urandom(), $urandom());
                live_addrs.delete();
            end
            else
                send_req(FUNC_UNUSED, $urandom(), $urandom());
        end
        in_valid <= 1'b0;
    endtask

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_first_fit_segment_allocator_core NOT OK");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before init, then the default window
        send_req(FUNC_ALLOC, 32'd10, 32'd0);
        send_req(FUNC_FREE, 32'd0, 32'd16);
        send_req(FUNC_FREE, 32'd0, 32'd0);
        send_req(FUNC_INIT, 32'hffff_ffff, 32'hffff_ffff);
        send_req(FUNC_ALLOC, 32'd0, 32'd0);
        send_req(FUNC_ALLOC, 32'hffff_ffff, 32'd0);
        send_req(FUNC_ALLOC, 32'hffff_ffc1, 32'd0);
        send_req(FUNC_ALLOC, 32'd1, 32'd0);
        send_req(FUNC_ALLOC, 32'd64, 32'd0);
        send_req(FUNC_ALLOC, 32'd65, 32'd0);
        send_req(FUNC_FREE, 32'd0, 32'd16 + 32'd64 + 32'd16);
        send_req(FUNC_FREE, 32'd0, 32'd16);
        send_req(FUNC_FREE, 32'd0, 32'd16);
        send_req(FUNC_FREE, 32'd0, 32'd208);
        send_req(FUNC_FREE, 32'd0, 32'd1048576);
        send_req(FUNC_FREE, 32'd0, 32'd5);
        send_req(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        // Fill the table until the split is refused
        for (int i = 0; i < 66; i++)
            send_req(FUNC_ALLOC, 32'd1, 32'd0);

        // Heap too small, then exactly one header
        set_heap(32'd1000, 32'd1015);
        send_req(FUNC_INIT, 32'd0, 32'd0);
        send_req(FUNC_ALLOC, 32'd1, 32'd0);
        set_heap(32'd1000, 32'd1016);
        send_req(FUNC_INIT, 32'd0, 32'd0);
        send_req(FUNC_ALLOC, 32'd1, 32'd0);

        // Random windows, including the top of the address space
        set_heap(32'h0000_0100, 32'h0000_2100);
        run_traffic(170);
        set_heap(32'hffff_e000, 32'hffff_ffff);
        run_traffic(130);
        set_heap(32'd0, 32'hffff_ffff);
        run_traffic(130);
        set_heap($urandom_range(0, 1 << 20) & ~32'hf, 32'h0030_0000);
        run_traffic(170);

        wait_quiet();
        if (fail_count == 0)
            $display("tb_first_fit_segment_allocator_core OK");
        else
            $display("tb_first_fit_segment_allocator_core NOT OK");
        $finish;
    end

endmodule
